// ===== rtl/pptc_pkg.sv =====
// ----------------------------------------------------------------------------
// pptc_pkg
// Shared types and constants of the port/protocol traffic classifier.
// ----------------------------------------------------------------------------
package pptc_pkg;

    typedef enum logic [2:0] {
        OP_SET_CLASS   = 3'd0,
        OP_DEL_CLASS   = 3'd1,
        OP_QUERY_CLASS = 3'd2,
        OP_SET_DEFAULT = 3'd3,
        OP_SET_RULE    = 3'd4,
        OP_DEL_RULE    = 3'd5,
        OP_QUERY_RULE  = 3'd6,
        OP_CLASSIFY    = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_INACTIVE = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOMATCH  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } fsm_t;

    localparam logic [7:0]  NULL_CLASS   = 8'd255;
    localparam logic [7:0]  PROTO_TCP    = 8'h06;
    localparam logic [7:0]  PROTO_UDP    = 8'h11;
    localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
    localparam logic [15:0] PROTO_POS    = 16'd23;
    localparam logic [15:0] PORT_POS     = 16'd36;
    localparam logic [3:0]  IPV4_VERSION = 4'h4;

    // key travelling down the rule chain
    typedef struct packed {
        logic        wr_set;
        logic        wr_del;
        logic [15:0] port;
        logic        tcp;
        logic [7:0]  cls;
    } rule_key_t;

    // running search result handed from cell to cell
    typedef struct packed {
        logic       eq_found;
        logic       eq_valid;
        logic [7:0] eq_class;
        logic       free_found;
        logic       del_found;
        logic       claimed;
    } rule_scan_t;

endpackage

// ===== rtl/pptc_rule_cell.sv =====
// ----------------------------------------------------------------------------
// pptc_rule_cell
// One rule entry: compares the key, passes the running match to its neighbor
// and applies insert or delete when it is the first eligible entry.
// ----------------------------------------------------------------------------
module pptc_rule_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  commit,
    input  pptc_pkg::rule_key_t   key,
    input  pptc_pkg::rule_scan_t  scan_in,
    output pptc_pkg::rule_scan_t  scan_out
);
    import pptc_pkg::*;

    logic [15:0] port_reg;
    logic        tcp_reg;
    logic [7:0]  class_reg;
    logic        valid_reg;
    logic        eq;
    logic        take_set;
    logic        take_del;

    assign eq       = (port_reg == key.port) && (tcp_reg == key.tcp);
    assign take_set = !scan_in.claimed && (eq || !valid_reg);
    assign take_del = !scan_in.del_found && valid_reg && eq && (class_reg == key.cls);

    always_comb
    begin
        scan_out = scan_in;
        if (!scan_in.eq_found && eq)
        begin
            scan_out.eq_found = 1'b1;
            scan_out.eq_valid = valid_reg;
            scan_out.eq_class = class_reg;
        end
        if (take_set)
        begin
            scan_out.claimed = 1'b1;
        end
        if (!valid_reg)
        begin
            scan_out.free_found = 1'b1;
        end
        if (take_del)
        begin
            scan_out.del_found = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_reg  <= '0;
            tcp_reg   <= 1'b0;
            class_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            if (key.wr_set && take_set)
            begin
                port_reg  <= key.port;
                tcp_reg   <= key.tcp;
                class_reg <= key.cls;
                valid_reg <= 1'b1;
            end
            else if (key.wr_del && take_del)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/pptc_rule_chain.sv =====
// ----------------------------------------------------------------------------
// pptc_rule_chain
// Row of rule cells; the first cell in the row has priority.
// ----------------------------------------------------------------------------
module pptc_rule_chain #(
    parameter int RULE_ENTRIES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  commit,
    input  pptc_pkg::rule_key_t   key,
    output pptc_pkg::rule_scan_t  scan
);
    import pptc_pkg::*;

    rule_scan_t link [RULE_ENTRIES+1];

    assign link[0] = '0;

    for (genvar i = 0; i < RULE_ENTRIES; i++)
    begin : g_cell
        pptc_rule_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .commit   (commit),
            .key      (key),
            .scan_in  (link[i]),
            .scan_out (link[i+1])
        );
    end

    assign scan = link[RULE_ENTRIES];

endmodule

// ===== rtl/port_protocol_traffic_classifier_top.sv =====
// ----------------------------------------------------------------------------
// port_protocol_traffic_classifier_top
// Class table, default class and a chain of rule cells behind valid/ready.
// ----------------------------------------------------------------------------
// The input transfer is captured in S_IDLE, the rule cell chain is scanned and
// committed in S_SCAN, and the result is held valid in S_DONE. Only one item is
// in flight: in_ready is high only in S_IDLE, so a new item is not taken until
// the result has been accepted with out_ready.
// Reset: all rules and classes inactive, default class null, enable low.
module port_protocol_traffic_classifier_top #(
    parameter int RULE_ENTRIES = 16,
    parameter int NUM_CLASSES  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [7:0]  class_id,
    input  logic [7:0]  param_k,
    input  logic [7:0]  param_h,
    input  logic [15:0] timeout_value,
    input  logic [15:0] port_number,
    input  logic        tcp_flag,
    input  logic [15:0] packet_length,
    input  logic [7:0]  ip_first_byte,
    input  logic [7:0]  ip_protocol_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  result_class,
    output logic [7:0]  out_k,
    output logic [7:0]  out_h,
    output logic [15:0] out_timeout
);
    import pptc_pkg::*;

    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    fsm_t        state_reg, state_next;
    logic        enable_reg;
    logic [7:0]  default_reg;
    logic [7:0]  k_mem   [NUM_CLASSES];
    logic [7:0]  h_mem   [NUM_CLASSES];
    logic [15:0] t_mem   [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] cvalid_reg;

    opcode_t     op_reg;
    logic [7:0]  cid_reg, pk_reg, ph_reg;
    logic [15:0] pt_reg, port_reg, plen_reg;
    logic        tcp_reg;
    logic [7:0]  b14_reg, b23_reg;

    logic [2:0]  status_reg;
    logic [7:0]  rc_reg, ok_reg, oh_reg;
    logic [15:0] ot_reg;

    rule_key_t   key;
    rule_scan_t  scan;
    logic        commit;
    logic        cid_in_range;
    logic [CW-1:0] cidx;
    logic        cls_active;
    status_t     chk;
    logic        cls_ok;
    logic        pkt_ipv4, pkt_proto_ok, pkt_tcp, pkt_lookup;
    logic [7:0]  lookup_class;
    status_t     st_c;
    logic [7:0]  rc_c, ok_c, oh_c;
    logic [15:0] ot_c;

    assign pready = 1'b1;
    assign prdata = {31'd0, enable_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            enable_reg <= pwdata[0];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_SCAN;
            S_SCAN:  state_next = S_DONE;
            S_DONE:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= opcode_t'(opcode);
            cid_reg  <= class_id;
            pk_reg   <= param_k;
            ph_reg   <= param_h;
            pt_reg   <= timeout_value;
            port_reg <= port_number;
            tcp_reg  <= tcp_flag;
            plen_reg <= packet_length;
            b14_reg  <= ip_first_byte;
            b23_reg  <= ip_protocol_byte;
        end
    end

    assign cid_in_range = ({1'b0, cid_reg} < 9'(NUM_CLASSES));
    assign cidx         = cid_reg[CW-1:0];
    assign cls_active   = cid_in_range && cvalid_reg[cidx];

    always_comb
    begin
        if (cid_reg == NULL_CLASS) chk = ST_OK;
        else if (!cid_in_range)    chk = ST_RANGE;
        else if (!cls_active)      chk = ST_INACTIVE;
        else                       chk = ST_OK;
    end
    assign cls_ok = (chk == ST_OK);

    assign pkt_ipv4     = (plen_reg >= ETH_HDR_LEN) && (b14_reg[7:4] == IPV4_VERSION);
    assign pkt_proto_ok = (b23_reg == PROTO_TCP) || (b23_reg == PROTO_UDP);
    assign pkt_tcp      = (b23_reg == PROTO_TCP);
    assign pkt_lookup   = pkt_ipv4 && (plen_reg >= PROTO_POS) && pkt_proto_ok;

    always_comb
    begin
        key.wr_set = (op_reg == OP_SET_RULE) && cls_ok;
        key.wr_del = (op_reg == OP_DEL_RULE);
        key.cls    = cid_reg;
        if (op_reg == OP_CLASSIFY)
        begin
            key.port = (plen_reg < PORT_POS) ? 16'd0 : port_reg;
            key.tcp  = pkt_tcp;
        end
        else
        begin
            key.port = port_reg;
            key.tcp  = tcp_reg;
        end
    end

    assign commit = (state_reg == S_SCAN);

    pptc_rule_chain #(
        .RULE_ENTRIES (RULE_ENTRIES)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .key    (key),
        .scan   (scan)
    );

    always_comb
    begin
        if (!enable_reg)                        lookup_class = NULL_CLASS;
        else if (scan.eq_found && scan.eq_valid) lookup_class = scan.eq_class;
        else                                     lookup_class = default_reg;
    end

    always_comb
    begin
        st_c = ST_OK;
        rc_c = NULL_CLASS;
        ok_c = '0;
        oh_c = '0;
        ot_c = '0;
        case (op_reg)
            OP_SET_CLASS, OP_DEL_CLASS:
            begin
                if (!cid_in_range) st_c = ST_RANGE;
            end
            OP_QUERY_CLASS:
            begin
                if (!cid_in_range)    st_c = ST_RANGE;
                else if (!cls_active) st_c = ST_INACTIVE;
                else
                begin
                    rc_c = cid_reg;
                    ok_c = k_mem[cidx];
                    oh_c = h_mem[cidx];
                    ot_c = t_mem[cidx];
                end
            end
            OP_SET_DEFAULT: st_c = chk;
            OP_SET_RULE:
            begin
                if (!cls_ok)             st_c = chk;
                else if (!scan.claimed)  st_c = ST_FULL;
            end
            OP_DEL_RULE:
            begin
                if (!scan.del_found) st_c = ST_NOMATCH;
            end
            OP_QUERY_RULE: rc_c = lookup_class;
            OP_CLASSIFY:   rc_c = pkt_lookup ? lookup_class : default_reg;
            default:       st_c = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_reg <= NULL_CLASS;
            cvalid_reg  <= '0;
        end
        else if (commit)
        begin
            if (op_reg == OP_SET_DEFAULT && cls_ok)
            begin
                default_reg <= cid_reg;
            end
            if (op_reg == OP_SET_CLASS && cid_in_range)
            begin
                cvalid_reg[cidx] <= 1'b1;
            end
            if (op_reg == OP_DEL_CLASS && cid_in_range)
            begin
                cvalid_reg[cidx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && op_reg == OP_SET_CLASS && cid_in_range)
        begin
            k_mem[cidx] <= pk_reg;
            h_mem[cidx] <= ph_reg;
            t_mem[cidx] <= pt_reg;
        end
        if (commit)
        begin
            status_reg <= st_c;
            rc_reg     <= rc_c;
            ok_reg     <= ok_c;
            oh_reg     <= oh_c;
            ot_reg     <= ot_c;
        end
    end

    assign status       = status_reg;
    assign result_class = rc_reg;
    assign out_k        = ok_reg;
    assign out_h        = oh_reg;
    assign out_timeout  = ot_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic classifier testbench
// Drives class, default, rule, lookup and classify operations through the
// item channel, predicts each result from a local copy of the class and rule
// tables, and compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import pptc_pkg::*;

    localparam int NRULES   = 16;
    localparam int NCLASSES = 16;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic [2:0]  st;
        logic [7:0]  cls;
        logic [7:0]  k;
        logic [7:0]  h;
        logic [15:0] tmo;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic [7:0]  class_id;
    logic [7:0]  param_k;
    logic [7:0]  param_h;
    logic [15:0] timeout_value;
    logic [15:0] port_number;
    logic        tcp_flag;
    logic [15:0] packet_length;
    logic [7:0]  ip_first_byte;
    logic [7:0]  ip_protocol_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [7:0]  result_class;
    logic [7:0]  out_k;
    logic [7:0]  out_h;
    logic [15:0] out_timeout;

    logic [15:0] m_rule_port [NRULES];
    logic        m_rule_tcp [NRULES];
    logic [7:0]  m_rule_class [NRULES];
    logic        m_rule_on [NRULES];
    logic [7:0]  m_cls_k [NCLASSES];
    logic [7:0]  m_cls_h [NCLASSES];
    logic [15:0] m_cls_tmo [NCLASSES];
    logic        m_cls_on [NCLASSES];
    logic [7:0]  m_default;
    logic        m_enable;

    verdict_t pending_verdicts[$];
    int       mismatches;
    int       transfers_sent;
    int       results_seen;
    longint   cycle_count;
    bit       calm;
    logic [15:0] port_pool [8];

    port_protocol_traffic_classifier_top dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [2:0] class_usable(logic [7:0] c);
        if (c == NULL_CLASS)
            return ST_OK;
        if (c >= NCLASSES)
            return ST_RANGE;
        return m_cls_on[c] ? ST_OK : ST_INACTIVE;
    endfunction

    function automatic logic [7:0] match_rule(logic [15:0] port, logic tcp);
        if (!m_enable)
            return NULL_CLASS;
        for (int i = 0; i < NRULES; i++)
            if (m_rule_port[i] == port && m_rule_tcp[i] == tcp)
                return m_rule_on[i] ? m_rule_class[i] : m_default;
        return m_default;
    endfunction

    function automatic verdict_t classify_item(logic [2:0] op, logic [7:0] cid,
        logic [7:0] pk, logic [7:0] ph, logic [15:0] pt, logic [15:0] port,
        logic tcp, logic [15:0] plen, logic [7:0] b14, logic [7:0] b23);
        verdict_t v;
        bit done;
        v = '{st: ST_OK, cls: NULL_CLASS, k: 8'd0, h: 8'd0, tmo: 16'd0};
        done = 0;
        case (op)
            OP_SET_CLASS:
                if (cid >= NCLASSES)
                    v.st = ST_RANGE;
                else
                begin
                    m_cls_k[cid] = pk;
                    m_cls_h[cid] = ph;
                    m_cls_tmo[cid] = pt;
                    m_cls_on[cid] = 1'b1;
                end
            OP_DEL_CLASS:
                if (cid >= NCLASSES)
                    v.st = ST_RANGE;
                else
                    m_cls_on[cid] = 1'b0;
            OP_QUERY_CLASS:
                if (cid >= NCLASSES)
                    v.st = ST_RANGE;
                else if (!m_cls_on[cid])
                    v.st = ST_INACTIVE;
                else
                begin
                    v.cls = cid;
                    v.k = m_cls_k[cid];
                    v.h = m_cls_h[cid];
                    v.tmo = m_cls_tmo[cid];
                end
            OP_SET_DEFAULT:
            begin
                v.st = class_usable(cid);
                if (v.st == ST_OK)
                    m_default = cid;
            end
            OP_SET_RULE:
            begin
                v.st = class_usable(cid);
                if (v.st == ST_OK)
                begin
                    v.st = ST_FULL;
                    for (int i = 0; i < NRULES && !done; i++)
                        if ((m_rule_port[i] == port && m_rule_tcp[i] == tcp) ||
                            !m_rule_on[i])
                        begin
                            m_rule_port[i] = port;
                            m_rule_tcp[i] = tcp;
                            m_rule_class[i] = cid;
                            m_rule_on[i] = 1'b1;
                            v.st = ST_OK;
                            done = 1;
                        end
                end
            end
            OP_DEL_RULE:
            begin
                v.st = ST_NOMATCH;
                for (int i = 0; i < NRULES && !done; i++)
                    if (m_rule_on[i] && m_rule_port[i] == port &&
                        m_rule_tcp[i] == tcp && m_rule_class[i] == cid)
                    begin
                        m_rule_on[i] = 1'b0;
                        v.st = ST_OK;
                        done = 1;
                    end
            end
            OP_QUERY_RULE:
                v.cls = match_rule(port, tcp);
            default:
                if (plen < ETH_HDR_LEN || b14[7:4] != IPV4_VERSION || plen < PROTO_POS)
                    v.cls = m_default;
                else if (b23 == PROTO_TCP)
                    v.cls = match_rule(plen < PORT_POS ? 16'd0 : port, 1'b1);
                else if (b23 == PROTO_UDP)
                    v.cls = match_rule(plen < PORT_POS ? 16'd0 : port, 1'b0);
                else
                    v.cls = m_default;
        endcase
        return v;
    endfunction

    task automatic idle_gap();
        while (!calm && $urandom_range(99) < 32)
            @(negedge clk);
    endtask

    task automatic send_item(logic [2:0] op, logic [7:0] cid, logic [7:0] pk,
        logic [7:0] ph, logic [15:0] pt, logic [15:0] port, logic tcp,
        logic [15:0] plen, logic [7:0] b14, logic [7:0] b23);
        idle_gap();
        opcode <= op;
        class_id <= cid;
        param_k <= pk;
        param_h <= ph;
        timeout_value <= pt;
        port_number <= port;
        tcp_flag <= tcp;
        packet_length <= plen;
        ip_first_byte <= b14;
        ip_protocol_byte <= b23;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_verdicts.push_back(classify_item(op, cid, pk, ph, pt, port, tcp,
            plen, b14, b23));
        transfers_sent++;
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_enable(logic val);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {31'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        m_enable = val;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_random(int n);
        logic [2:0]  op;
        logic [7:0]  cid;
        logic [15:0] port;
        logic [15:0] plen;
        logic [7:0]  b14;
        logic [7:0]  b23;
        int r;
        for (int i = 0; i < n; i++)
        begin
            op = 3'($urandom_range(7));
            r = $urandom_range(9);
            cid = r < 7 ? 8'($urandom_range(NCLASSES - 1)) :
                  (r < 8 ? NULL_CLASS : 8'($urandom));
            port = $urandom_range(3) != 0 ? port_pool[$urandom_range(7)] : 16'($urandom);
            r = $urandom_range(9);
            plen = r < 6 ? 16'($urandom_range(60, 36)) :
                   (r < 9 ? 16'($urandom_range(40)) : 16'($urandom));
            r = $urandom_range(9);
            b14 = r < 8 ? {4'h4, 4'($urandom)} : 8'($urandom);
            r = $urandom_range(9);
            b23 = r < 5 ? PROTO_TCP : (r < 9 ? PROTO_UDP : 8'($urandom));
            send_item(op, cid, 8'($urandom), 8'($urandom), 16'($urandom), port,
                1'($urandom), plen, b14, b23);
        end
    endtask

    task automatic test_directed();
        send_item(OP_QUERY_RULE, 0, 0, 0, 0, 16'd0, 1'b0, 0, 0, 0);
        send_item(OP_SET_CLASS, 8'd0, 8'hff, 8'h00, 16'hffff, 0, 0, 0, 0, 0);
        send_item(OP_SET_CLASS, 8'd15, 8'h00, 8'hff, 16'h0000, 0, 0, 0, 0, 0);
        send_item(OP_SET_CLASS, 8'd16, 1, 1, 1, 0, 0, 0, 0, 0);
        send_item(OP_SET_CLASS, NULL_CLASS, 1, 1, 1, 0, 0, 0, 0, 0);
        send_item(OP_QUERY_CLASS, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_QUERY_CLASS, 8'd7, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SET_DEFAULT, 8'd7, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SET_DEFAULT, 8'd200, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SET_DEFAULT, 8'd15, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SET_RULE, 8'd0, 0, 0, 0, 16'hffff, 1'b1, 0, 0, 0);
        send_item(OP_SET_RULE, NULL_CLASS, 0, 0, 0, 16'd0, 1'b0, 0, 0, 0);
        send_item(OP_SET_RULE, 8'd3, 0, 0, 0, 16'd80, 1'b0, 0, 0, 0);
        send_item(OP_QUERY_RULE, 0, 0, 0, 0, 16'hffff, 1'b1, 0, 0, 0);
        send_item(OP_CLASSIFY, 0, 0, 0, 0, 16'hffff, 0, 16'd36, 8'h45, PROTO_TCP);
        send_item(OP_CLASSIFY, 0, 0, 0, 0, 16'hffff, 0, 16'd35, 8'h45, PROTO_UDP);
        send_item(OP_CLASSIFY, 0, 0, 0, 0, 16'hffff, 0, 16'd22, 8'h45, PROTO_TCP);
        send_item(OP_CLASSIFY, 0, 0, 0, 0, 16'hffff, 0, 16'd13, 8'h45, PROTO_TCP);
        send_item(OP_CLASSIFY, 0, 0, 0, 0, 16'hffff, 0, 16'hffff, 8'h65, PROTO_TCP);
        send_item(OP_CLASSIFY, 0, 0, 0, 0, 16'hffff, 0, 16'hffff, 8'h4f, 8'h01);
        send_item(OP_DEL_RULE, 8'd0, 0, 0, 0, 16'hffff, 1'b1, 0, 0, 0);
        send_item(OP_DEL_RULE, 8'd0, 0, 0, 0, 16'hffff, 1'b1, 0, 0, 0);
        send_item(OP_QUERY_RULE, 0, 0, 0, 0, 16'hffff, 1'b1, 0, 0, 0);
        send_item(OP_DEL_CLASS, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_DEL_CLASS, 8'd99, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_table_full();
        send_item(OP_SET_CLASS, 8'd2, 1, 2, 3, 0, 0, 0, 0, 0);
        for (int i = 0; i < NRULES + 2; i++)
            send_item(OP_SET_RULE, 8'd2, 0, 0, 0, 16'(1000 + i), 1'b1, 0, 0, 0);
        send_item(OP_SET_RULE, 8'd2, 0, 0, 0, 16'd1003, 1'b1, 0, 0, 0);
        send_item(OP_QUERY_RULE, 0, 0, 0, 0, 16'd1003, 1'b1, 0, 0, 0);
        for (int i = 0; i < NRULES; i++)
            send_item(OP_DEL_RULE, 8'd2, 0, 0, 0, 16'(1000 + i), 1'b1, 0, 0, 0);
    endtask

    task automatic test_random_mix();
        send_random(400);
        calm = 1;
        send_random(200);
        calm = 0;
        drain();
        send_random(400);
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d class=%0d", status, result_class);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (status !== want.st || result_class !== want.cls || out_k !== want.k ||
                    out_h !== want.h || out_timeout !== want.tmo)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d cls=%0d k=%0d h=%0d t=%0d",
                            want.st, want.cls, want.k, want.h, want.tmo,
                            " got st=%0d cls=%0d k=%0d h=%0d t=%0d",
                            status, result_class, out_k, out_h, out_timeout);
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 2'd0;
        pwdata = 32'd0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = OP_QUERY_RULE;
        class_id = 0;
        param_k = 0;
        param_h = 0;
        timeout_value = 0;
        port_number = 0;
        tcp_flag = 0;
        packet_length = 0;
        ip_first_byte = 0;
        ip_protocol_byte = 0;
        mismatches = 0;
        transfers_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        calm = 0;
        for (int i = 0; i < NRULES; i++)
        begin
            m_rule_port[i] = 0;
            m_rule_tcp[i] = 0;
            m_rule_class[i] = 0;
            m_rule_on[i] = 0;
        end
        for (int i = 0; i < NCLASSES; i++)
        begin
            m_cls_k[i] = 0;
            m_cls_h[i] = 0;
            m_cls_tmo[i] = 0;
            m_cls_on[i] = 0;
        end
        m_default = NULL_CLASS;
        m_enable = 1'b0;
        for (int i = 0; i < 8; i++)
            port_pool[i] = i < 2 ? (i == 0 ? 16'd0 : 16'hffff) : 16'($urandom);
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        write_enable(1'b1);
        test_directed();
        test_table_full();
        test_random_mix();
        write_enable(1'b0);
        send_random(150);
        write_enable(1'b1);
        send_random(400);
        drain();
        $display("covered %0d transfers and %0d results over all opcodes,", transfers_sent,
            results_seen);
        $display("both enable settings, full rule table and packet header corner cases");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
